// ===== hdl/plshed_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Priority-ordered load shedder: shared package
// Sizes, the stored task record and the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package plshed_pkg;

  localparam int MaxTasks = 64;
  localparam int CntW     = $clog2(MaxTasks + 1);
  localparam int TagW     = 8;
  localparam int PrioW    = 8;
  localparam int CostW    = 16;
  localparam int ExcInW   = 24;
  localparam int ExcW     = ExcInW + 1;
  localparam int KeptW    = 7;

  typedef struct packed {
    logic [TagW-1:0]  tag;
    logic [PrioW-1:0] prio;
    logic [CostW-1:0] cost;
  } task_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;   // insert the input task into the chain
    logic start;  // capture the excess load of the last beat
    logic pop;    // drop the head cell after a shed beat
    logic clear;  // empty the list at the end of the trim
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic shed_avail;  // a task will be shed on the current result beat
    logic run_end;     // the current shed beat is the final one
  } dp_status_t;

endpackage : plshed_pkg
`default_nettype wire

// ===== hdl/plshed_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Priority-ordered load shedder: controller
// Two-state machine: load tasks, then deliver the trim beats.
// ----------------------------------------------------------------------------
module plshed_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic                   last_task_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  input  wire plshed_pkg::dp_status_t status_i,
  output plshed_pkg::dp_cmd_t         cmd_o
);
  import plshed_pkg::*;

  typedef enum logic [1:0] {
    StLoad = 2'b01,
    StTrim = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   in_acc, out_acc;

  assign in_ready_o  = (state_q == StLoad);
  assign out_valid_o = (state_q == StTrim);
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_acc     = out_valid_o & out_ready_i;

  always_comb begin
    cmd_o.load  = in_acc;
    cmd_o.start = in_acc & last_task_i;
    cmd_o.pop   = out_acc & status_i.shed_avail;
    cmd_o.clear = out_acc & (~status_i.shed_avail | status_i.run_end);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StLoad: begin
        if (in_acc && last_task_i) state_d = StTrim;
      end
      StTrim: begin
        if (cmd_o.clear) state_d = StLoad;
      end
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
    end else begin
      state_q <= state_d;
    end
  end

endmodule : plshed_ctrl
`default_nettype wire

// ===== hdl/plshed_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Priority-ordered load shedder: datapath
// Insertion-sorted cell chain, task count and remaining excess.
// ----------------------------------------------------------------------------
module plshed_dp (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [plshed_pkg::TagW-1:0]    task_tag_i,
  input  wire logic [plshed_pkg::PrioW-1:0]   task_priority_i,
  input  wire logic [plshed_pkg::CostW-1:0]   task_cost_i,
  input  wire logic signed [plshed_pkg::ExcInW-1:0] excess_load_i,
  input  wire plshed_pkg::dp_cmd_t            cmd_i,
  output plshed_pkg::dp_status_t              status_o,
  output logic                                moved_valid_o,
  output logic [plshed_pkg::TagW-1:0]         moved_tag_o,
  output logic [plshed_pkg::PrioW-1:0]        moved_priority_o,
  output logic [plshed_pkg::CostW-1:0]        moved_cost_o,
  output logic [plshed_pkg::KeptW-1:0]        kept_count_o,
  output logic                                end_of_run_o
);
  import plshed_pkg::*;

  // Cell 0 holds the next task to shed: the chain runs in ascending priority,
  // and among equal priorities the later task sits nearer the head.
  task_t                 cell_q [MaxTasks];
  task_t                 cell_d [MaxTasks];
  logic [MaxTasks-1:0]   stay;
  task_t                 new_task;
  logic [CntW-1:0]       count_q, count_d;
  logic signed [ExcW-1:0] excess_q, excess_d, excess_nxt;
  logic                  full, shed;

  assign new_task = '{tag: task_tag_i, prio: task_priority_i, cost: task_cost_i};
  assign full     = (count_q == CntW'(MaxTasks));

  always_comb begin
    for (int i = 0; i < MaxTasks; i++) begin
      stay[i] = (CntW'(i) < count_q) && (cell_q[i].prio < task_priority_i);
    end
  end

  always_comb begin
    for (int i = 0; i < MaxTasks; i++) begin
      cell_d[i] = cell_q[i];
    end
    if (cmd_i.load && !full) begin
      if (!stay[0]) cell_d[0] = new_task;
      for (int i = 1; i < MaxTasks; i++) begin
        if (!stay[i]) begin
          cell_d[i] = stay[i-1] ? new_task : cell_q[i-1];
        end
      end
    end else if (cmd_i.pop) begin
      for (int i = 0; i < MaxTasks - 1; i++) begin
        cell_d[i] = cell_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxTasks; i++) begin
      cell_q[i] <= cell_d[i];
    end
  end

  assign shed       = !excess_q[ExcW-1] && (excess_q != '0) && (count_q != '0);
  assign excess_nxt = excess_q - $signed({{(ExcW-CostW){1'b0}}, cell_q[0].cost});

  always_comb begin
    status_o.shed_avail = shed;
    status_o.run_end    = excess_nxt[ExcW-1] || (excess_nxt == '0)
                          || (count_q == CntW'(1));
  end

  always_comb begin
    count_d  = count_q;
    excess_d = excess_q;
    if (cmd_i.load && !full) count_d = count_q + CntW'(1);
    if (cmd_i.start) excess_d = ExcW'(excess_load_i);
    if (cmd_i.pop) begin
      count_d  = count_q - CntW'(1);
      excess_d = excess_nxt;
    end
    if (cmd_i.clear) begin
      count_d  = '0;
      excess_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      excess_q <= '0;
    end else begin
      count_q  <= count_d;
      excess_q <= excess_d;
    end
  end

  assign moved_valid_o    = shed;
  assign moved_tag_o      = shed ? cell_q[0].tag  : '0;
  assign moved_priority_o = shed ? cell_q[0].prio : '0;
  assign moved_cost_o     = shed ? cell_q[0].cost : '0;
  assign kept_count_o     = KeptW'(shed ? count_q - CntW'(1) : count_q);
  assign end_of_run_o     = shed ? status_o.run_end : 1'b1;

endmodule : plshed_dp
`default_nettype wire

// ===== hdl/priority_ordered_load_shedder_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Priority-ordered load shedder
// Loads a list of tasks into a sorted cell chain, then sheds the lowest
// priority tasks until the excess load given with the last task is covered.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one task per beat. A beat with last_task_i low is
//   inserted into the sorted chain in the cycle it is accepted and gives no
//   result, so loading runs at one beat per cycle. Tasks beyond 64 are dropped.
//   The beat with last_task_i high is inserted as well and starts the trim;
//   the input then stays not ready until the trim's final result is taken.
//   The trim gives one result beat per cycle when not stalled, each straight
//   from the head cell of the chain, the first one in the cycle after the last
//   task is accepted. If nothing is shed, one beat with moved_valid_o low is given.
//   end_of_run_o marks the final beat, after which the list is empty.
//   When the receiver stalls, the head cell and count simply hold, so the
//   result beat stays unchanged until taken.
//   Reset empties the list and returns the block to loading. No clearing
//   pass is needed.
// ----------------------------------------------------------------------------
module priority_ordered_load_shedder_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [plshed_pkg::TagW-1:0]   task_tag_i,
  input  wire logic [plshed_pkg::PrioW-1:0]  task_priority_i,
  input  wire logic [plshed_pkg::CostW-1:0]  task_cost_i,
  input  wire logic signed [plshed_pkg::ExcInW-1:0] excess_load_i,
  input  wire logic                          last_task_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               moved_valid_o,
  output logic [plshed_pkg::TagW-1:0]        moved_tag_o,
  output logic [plshed_pkg::PrioW-1:0]       moved_priority_o,
  output logic [plshed_pkg::CostW-1:0]       moved_cost_o,
  output logic [plshed_pkg::KeptW-1:0]       kept_count_o,
  output logic                               end_of_run_o
);
  import plshed_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  plshed_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .last_task_i (last_task_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  plshed_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .task_tag_i       (task_tag_i),
    .task_priority_i  (task_priority_i),
    .task_cost_i      (task_cost_i),
    .excess_load_i    (excess_load_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .moved_valid_o    (moved_valid_o),
    .moved_tag_o      (moved_tag_o),
    .moved_priority_o (moved_priority_o),
    .moved_cost_o     (moved_cost_o),
    .kept_count_o     (kept_count_o),
    .end_of_run_o     (end_of_run_o)
  );

endmodule : priority_ordered_load_shedder_top
`default_nettype wire
